/* hw/rtl/txbp_pkg.sv */
// Shared types and codes for the transmit buffer pool descriptor ring.
// No dependencies.
package txbp_pkg;

  localparam int PAGES = 64;

  typedef enum logic [1:0] {
    REQ_GET_PAGE = 2'd0,
    REQ_TRANSMIT = 2'd1,
    REQ_FREE     = 2'd2,
    REQ_NIC_DONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    PAGE_FREE = 2'd0,
    PAGE_OUT  = 2'd1,
    PAGE_TX   = 2'd2
  } page_st_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_OVERRUN     = 4'd1,
    ST_MISMATCH    = 4'd2,
    ST_OK_MISUSE   = 4'd3,
    ST_CLOSED      = 4'd4,
    ST_NIC_BUSY    = 4'd5,
    ST_NOT_SENDING = 4'd6,
    ST_BAD_INDEX   = 4'd7,
    ST_ZERO_LEN    = 4'd8,
    ST_OVER_MTU    = 4'd9,
    ST_BAD_DEST    = 4'd10,
    ST_FREE_BAD    = 4'd11
  } status_t;

  typedef enum logic [2:0] {
    BK_CLEAR    = 3'd0,
    BK_IDLE     = 3'd1,
    BK_EXEC     = 3'd2,
    BK_GET_SLOT = 3'd3,
    BK_RECLAIM  = 3'd4,
    BK_POST     = 3'd5
  } back_st_t;

  localparam logic [1:0] CFG_READY    = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN  = 2'd1;
  localparam logic [1:0] CFG_MAX_DEST = 2'd2;
  localparam logic [1:0] CFG_TEST_DST = 2'd3;

  typedef struct packed {
    req_t        req_type;
    logic [7:0]  page_index;
    logic [15:0] destination;
    logic [15:0] length;
    logic [5:0]  done_slot;
  } item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [5:0]  granted_page;
    logic        post_valid;
    logic [5:0]  post_slot;
    logic [15:0] post_destination;
    logic [15:0] post_length;
  } result_t;

endpackage

/* hw/rtl/txbp_front.sv */
// Front end: accepts request beats into a two-entry queue.
// Depends on txbp_pkg.
module txbp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  txbp_pkg::item_t in_item,
  output logic            q_valid,
  input  logic            q_ready,
  output txbp_pkg::item_t q_item
);
  import txbp_pkg::*;

  item_t      mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = mem[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_item;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* hw/rtl/txbp_back.sv */
// Back end: generic registered-read RAM, page and slot tables, request
// sequencing and result register. Depends on txbp_pkg.
module txbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

module txbp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  txbp_pkg::item_t   q_item,
  input  logic              cfg_ready,
  input  logic [15:0]       cfg_max_len,
  input  logic [15:0]       cfg_max_dest,
  input  logic [15:0]       cfg_test_dest,
  output logic              out_valid,
  input  logic              out_ready,
  output txbp_pkg::result_t out_res
);
  import txbp_pkg::*;

  back_st_t    state, state_next;
  item_t       req;
  result_t     res, res_next;
  logic [5:0]  clr_idx;
  logic [63:0] slot_busy;
  logic [63:0] slot_has;
  logic [5:0]  post_ptr;
  logic [5:0]  grant_ptr;

  logic        fin, grant, post, has_clr, done_clr, release_pi;
  logic [5:0]  has_clr_idx;
  logic        pi_ok;
  logic [5:0]  pi;

  logic        ps_we;
  logic [5:0]  ps_waddr, ps_raddr;
  page_st_t    ps_wdata;
  logic [1:0]  ps_q;
  logic [5:0]  rs_q;
  logic [5:0]  sp_raddr, sp_q;

  assign out_res = res;
  assign pi_ok   = (req.page_index < 8'(PAGES));
  assign pi      = req.page_index[5:0];

  txbp_ram #(.WIDTH(2), .DEPTH(PAGES)) u_page_state (
    .clk, .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .raddr(ps_raddr), .rdata(ps_q)
  );

  txbp_ram #(.WIDTH(6), .DEPTH(PAGES)) u_ring_slot (
    .clk, .we(post), .waddr(pi), .wdata(post_ptr),
    .raddr(grant_ptr), .rdata(rs_q)
  );

  txbp_ram #(.WIDTH(6), .DEPTH(PAGES)) u_slot_page (
    .clk, .we(post), .waddr(post_ptr), .wdata(pi),
    .raddr(sp_raddr), .rdata(sp_q)
  );

  always_comb begin
    state_next  = state;
    q_ready     = 1'b0;
    res_next    = '0;
    fin         = 1'b0;
    grant       = 1'b0;
    post        = 1'b0;
    has_clr     = 1'b0;
    has_clr_idx = post_ptr;
    done_clr    = 1'b0;
    release_pi  = 1'b0;
    ps_we       = 1'b0;
    ps_waddr    = pi;
    ps_wdata    = PAGE_FREE;
    ps_raddr    = grant_ptr;
    sp_raddr    = post_ptr;
    case (state)
      BK_CLEAR: begin
        ps_we    = 1'b1;
        ps_waddr = clr_idx;
        if (clr_idx == 6'(PAGES - 1)) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        q_ready = !out_valid || out_ready;
        if (q_valid && q_ready) state_next = BK_EXEC;
      end
      BK_EXEC: begin
        case (req.req_type)
          REQ_GET_PAGE: begin
            if (ps_q != PAGE_TX) begin
              grant = 1'b1;
              fin   = 1'b1;
              res_next.status = (ps_q == PAGE_FREE) ? ST_OK : ST_OK_MISUSE;
            end else begin
              sp_raddr   = rs_q;
              state_next = BK_GET_SLOT;
            end
          end
          REQ_TRANSMIT: begin
            if (!cfg_ready) begin
              res_next.status = ST_CLOSED;
              release_pi = 1'b1;
              fin        = 1'b1;
            end else if (slot_busy[post_ptr]) begin
              res_next.status = ST_NIC_BUSY;
              release_pi = 1'b1;
              fin        = 1'b1;
            end else if (slot_has[post_ptr]) begin
              ps_raddr   = sp_q;
              state_next = BK_RECLAIM;
            end else begin
              state_next = BK_POST;
            end
          end
          REQ_FREE: begin
            if (pi_ok) release_pi = 1'b1;
            else res_next.status = ST_FREE_BAD;
            fin = 1'b1;
          end
          default: begin
            done_clr = 1'b1;
            fin      = 1'b1;
          end
        endcase
      end
      BK_GET_SLOT: begin
        fin = 1'b1;
        if (slot_busy[rs_q]) begin
          res_next.status = ST_OVERRUN;
        end else if (!slot_has[rs_q] || sp_q != grant_ptr) begin
          res_next.status = ST_MISMATCH;
        end else begin
          grant       = 1'b1;
          has_clr     = 1'b1;
          has_clr_idx = rs_q;
          res_next.status = ST_OK;
        end
      end
      BK_RECLAIM: begin
        if (ps_q != PAGE_TX) begin
          res_next.status = ST_NOT_SENDING;
          release_pi = 1'b1;
          fin        = 1'b1;
        end else begin
          ps_we      = 1'b1;
          ps_waddr   = sp_q;
          has_clr    = 1'b1;
          state_next = BK_POST;
        end
      end
      BK_POST: begin
        fin = 1'b1;
        if (!pi_ok) begin
          res_next.status = ST_BAD_INDEX;
        end else if (req.length == 16'd0) begin
          res_next.status = ST_ZERO_LEN;
          release_pi = 1'b1;
        end else if (req.length > cfg_max_len) begin
          res_next.status = ST_OVER_MTU;
          release_pi = 1'b1;
        end else if (req.destination > cfg_max_dest &&
                     req.destination != cfg_test_dest) begin
          res_next.status = ST_BAD_DEST;
          release_pi = 1'b1;
        end else begin
          post     = 1'b1;
          ps_we    = 1'b1;
          ps_wdata = PAGE_TX;
          res_next.post_valid       = 1'b1;
          res_next.post_slot        = post_ptr;
          res_next.post_destination = req.destination;
          res_next.post_length      = req.length;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
    if (grant) begin
      ps_we    = 1'b1;
      ps_waddr = grant_ptr;
      ps_wdata = PAGE_OUT;
      res_next.granted_page = grant_ptr;
    end
    if (release_pi && pi_ok) ps_we = 1'b1;
    if (fin) state_next = BK_IDLE;
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && q_valid && q_ready) req <= q_item;
    if (fin) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_idx   <= '0;
      slot_busy <= '0;
      slot_has  <= '0;
      post_ptr  <= '0;
      grant_ptr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) clr_idx <= clr_idx + 6'd1;
      if (grant) grant_ptr <= grant_ptr + 6'd1;
      if (has_clr) slot_has[has_clr_idx] <= 1'b0;
      if (post) begin
        slot_has[post_ptr]  <= 1'b1;
        slot_busy[post_ptr] <= 1'b1;
        post_ptr <= post_ptr + 6'd1;
      end
      if (done_clr) slot_busy[req.done_slot] <= 1'b0;
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

/* hw/rtl/tx_buffer_pool_descriptor_ring.sv */
// Top level of the transmit buffer pool with descriptor ring.
// Depends on txbp_pkg, txbp_front, txbp_back.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid / in_ready     req_type .. done_slot
//   out      source     out_valid / out_ready   status .. post_length
//   cfg      sink       cfg_write               cfg_index, cfg_data
//
// The back end runs one request at a time: BK_IDLE pops it and reads the
// tables, BK_EXEC ends most requests, a get_page on a sending page goes on
// to BK_GET_SLOT, a transmit with an empty slot to BK_POST, and a transmit
// that reclaims to BK_RECLAIM, then BK_POST. A request is taken only after
// the last has its result. After reset a pass clears the page table while
// the queue takes up to two beats. A stalled result holds the back end idle.
module tx_buffer_pool_descriptor_ring (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  page_index,
  input  logic [15:0] destination,
  input  logic [15:0] length,
  input  logic [5:0]  done_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [5:0]  granted_page,
  output logic        post_valid,
  output logic [5:0]  post_slot,
  output logic [15:0] post_destination,
  output logic [15:0] post_length,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import txbp_pkg::*;

  item_t       in_item, q_item;
  result_t     res;
  logic        q_valid, q_ready;
  logic        ready_to_send;
  logic [15:0] max_length, max_destination, test_destination;

  assign in_item.req_type    = req_t'(req_type);
  assign in_item.page_index  = page_index;
  assign in_item.destination = destination;
  assign in_item.length      = length;
  assign in_item.done_slot   = done_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_to_send    <= 1'b0;
      max_length       <= 16'd4096;
      max_destination  <= 16'd1024;
      test_destination <= 16'hFFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_READY:    ready_to_send    <= cfg_data[0];
        CFG_MAX_LEN:  max_length       <= cfg_data;
        CFG_MAX_DEST: max_destination  <= cfg_data;
        CFG_TEST_DST: test_destination <= cfg_data;
        default: ;
      endcase
    end
  end

  txbp_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  txbp_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .cfg_ready(ready_to_send), .cfg_max_len(max_length),
    .cfg_max_dest(max_destination), .cfg_test_dest(test_destination),
    .out_valid, .out_ready, .out_res(res)
  );

  assign status           = res.status;
  assign granted_page     = res.granted_page;
  assign post_valid       = res.post_valid;
  assign post_slot        = res.post_slot;
  assign post_destination = res.post_destination;
  assign post_length      = res.post_length;
endmodule

/* hw/rtl/txbp_checker.sv */
// Port-level checks for tx_buffer_pool_descriptor_ring, bound to the top.
// Depends on txbp_pkg.
module txbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  status,
  input logic [5:0]  granted_page,
  input logic        post_valid,
  input logic [5:0]  post_slot,
  input logic [15:0] post_length
);
  import txbp_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result changed while stalled");

  a_post_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && post_valid |-> status == ST_OK && post_length != 16'd0)
    else $error("post without ok status");

  a_no_post_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !post_valid |-> post_slot == 6'd0 && post_length == 16'd0)
    else $error("post fields set without post");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_FREE_BAD)
    else $error("status code out of range");

  a_grant_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted_page != 6'd0 |-> status == ST_OK || status == ST_OK_MISUSE)
    else $error("grant with failing status");
endmodule

bind tx_buffer_pool_descriptor_ring txbp_checker u_txbp_checker (
  .clk, .rst, .out_valid, .out_ready, .status, .granted_page,
  .post_valid, .post_slot, .post_length
);

/* sim/tb.sv */
// Testbench for tx_buffer_pool_descriptor_ring: random and directed requests,
// results checked against an in-bench model of the page pool and descriptor ring.
// Depends on txbp_pkg and the RTL top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import txbp_pkg::*;

  localparam int NPG = 64;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] req_type = '0;
  logic [7:0] page_index = '0;
  logic [15:0] destination = '0;
  logic [15:0] length = '0;
  logic [5:0] done_slot = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [3:0] status;
  logic [5:0] granted_page;
  logic post_valid;
  logic [5:0] post_slot;
  logic [15:0] post_destination;
  logic [15:0] post_length;
  logic cfg_write = 0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  tx_buffer_pool_descriptor_ring dut (.*);

  always #5 clk = ~clk;

  // model state
  logic        m_ready;
  logic [15:0] m_max_len, m_max_dest, m_test_dest;
  page_st_t    m_pstate[NPG];
  logic [5:0]  m_ring_slot[NPG];
  logic        m_busy[NPG];
  logic        m_has_page[NPG];
  logic [5:0]  m_slot_page[NPG];
  logic [5:0]  m_post_ptr, m_grant_ptr;

  result_t expected_results[$];
  int errors = 0;
  int idle_on = 1;
  int wdog = 0;
  int stall_left = 0;

  task automatic model_reset();
    m_ready = 1'b0; m_max_len = 16'd4096; m_max_dest = 16'd1024; m_test_dest = 16'hFFFF;
    for (int i = 0; i < NPG; i++) begin
      m_pstate[i] = PAGE_FREE; m_ring_slot[i] = '0; m_busy[i] = 1'b0;
      m_has_page[i] = 1'b0; m_slot_page[i] = '0;
    end
    m_post_ptr = '0; m_grant_ptr = '0;
  endtask

  function automatic void return_page(logic [7:0] pi);
    if (pi < NPG) m_pstate[pi[5:0]] = PAGE_FREE;
  endfunction

  function automatic result_t predict_request(item_t it);
    result_t r;
    logic [5:0] p, s;
    r = '0;
    case (it.req_type)
      REQ_GET_PAGE: begin
        p = m_grant_ptr;
        if (m_pstate[p] == PAGE_FREE || m_pstate[p] == PAGE_OUT) begin
          r.status = (m_pstate[p] == PAGE_FREE) ? ST_OK : ST_OK_MISUSE;
          m_pstate[p] = PAGE_OUT; r.granted_page = p; m_grant_ptr = p + 6'd1;
        end else begin
          s = m_ring_slot[p];
          if (m_busy[s]) r.status = ST_OVERRUN;
          else if (!m_has_page[s] || m_slot_page[s] != p) r.status = ST_MISMATCH;
          else begin
            m_has_page[s] = 1'b0; m_pstate[p] = PAGE_OUT;
            r.status = ST_OK; r.granted_page = p; m_grant_ptr = p + 6'd1;
          end
        end
      end
      REQ_TRANSMIT: begin
        p = m_post_ptr;
        if (!m_ready) begin
          return_page(it.page_index); r.status = ST_CLOSED; return r;
        end
        if (m_busy[p]) begin
          return_page(it.page_index); r.status = ST_NIC_BUSY; return r;
        end
        if (m_has_page[p]) begin
          if (m_pstate[m_slot_page[p]] != PAGE_TX) begin
            return_page(it.page_index); r.status = ST_NOT_SENDING; return r;
          end
          m_pstate[m_slot_page[p]] = PAGE_FREE; m_has_page[p] = 1'b0;
        end
        if (it.page_index >= NPG) r.status = ST_BAD_INDEX;
        else if (it.length == 0) r.status = ST_ZERO_LEN;
        else if (it.length > m_max_len) r.status = ST_OVER_MTU;
        else if (it.destination > m_max_dest && it.destination != m_test_dest)
          r.status = ST_BAD_DEST;
        else begin
          m_slot_page[p] = it.page_index[5:0]; m_has_page[p] = 1'b1; m_busy[p] = 1'b1;
          m_ring_slot[it.page_index[5:0]] = p; m_pstate[it.page_index[5:0]] = PAGE_TX;
          m_post_ptr = p + 6'd1;
          r.status = ST_OK; r.post_valid = 1'b1; r.post_slot = p;
          r.post_destination = it.destination; r.post_length = it.length;
          return r;
        end
        if (r.status != ST_BAD_INDEX) return_page(it.page_index);
      end
      REQ_FREE: begin
        if (it.page_index < NPG) m_pstate[it.page_index[5:0]] = PAGE_FREE;
        else r.status = ST_FREE_BAD;
      end
      default: m_busy[it.done_slot] = 1'b0;
    endcase
    return r;
  endfunction

  task automatic random_gap();
    int n;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 12);
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_request(logic [1:0] rq, logic [7:0] pi, logic [15:0] dst,
                              logic [15:0] len, logic [5:0] ds);
    item_t it;
    random_gap();
    it = '{req_type: req_t'(rq), page_index: pi, destination: dst, length: len,
           done_slot: ds};
    in_valid <= 1; req_type <= rq; page_index <= pi; destination <= dst;
    length <= len; done_slot <= ds;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(predict_request(it));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    case (idx)
      CFG_READY: m_ready = val[0];
      CFG_MAX_LEN: m_max_len = val;
      CFG_MAX_DEST: m_max_dest = val;
      default: m_test_dest = val;
    endcase
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    result_t got, exp;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{status, granted_page, post_valid, post_slot, post_destination,
                post_length};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat %h", got);
        end else begin
          exp = expected_results.pop_front();
          if (got !== exp) begin
            errors++;
            if (errors <= 10) $display("mismatch exp %h got %h", exp, got);
          end
        end
      end
      if (!idle_on) begin
        out_ready <= 1;
      end else if (stall_left > 0) begin
        out_ready <= 0;
        stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
        out_ready <= 0;
        stall_left = $urandom_range(0, 11);
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_closed_ring();
    send_request(REQ_GET_PAGE, 0, 0, 0, 0);
    send_request(REQ_TRANSMIT, 0, 5, 10, 0);
    send_request(REQ_TRANSMIT, 8'hFF, 5, 10, 0);
    send_request(REQ_FREE, 8'hFF, 0, 0, 0);
    send_request(REQ_FREE, 0, 0, 0, 0);
    send_request(REQ_NIC_DONE, 0, 0, 0, 6'h3F);
  endtask

  task automatic test_directed_checks();
    write_reg(CFG_READY, 16'd1);
    send_request(REQ_GET_PAGE, 0, 0, 0, 0);
    send_request(REQ_TRANSMIT, 0, 16'd1024, 16'd4096, 0);
    send_request(REQ_TRANSMIT, 1, 0, 1, 0);
    send_request(REQ_NIC_DONE, 0, 0, 0, 0);
    send_request(REQ_TRANSMIT, 64, 0, 1, 0);
    send_request(REQ_TRANSMIT, 2, 0, 0, 0);
    send_request(REQ_TRANSMIT, 2, 0, 16'd4097, 0);
    send_request(REQ_TRANSMIT, 2, 16'd1025, 16'd10, 0);
    send_request(REQ_TRANSMIT, 2, 16'hFFFF, 16'hFFFF, 0);
    send_request(REQ_TRANSMIT, 3, 16'hFFFF, 16'd1, 0);
    send_request(REQ_FREE, 3, 0, 0, 0);
    send_request(REQ_TRANSMIT, 4, 0, 1, 0);
    for (int i = 0; i < 4; i++) send_request(REQ_GET_PAGE, 0, 0, 0, 0);
  endtask

  task automatic random_phase(int n, int rq_bias);
    logic [1:0] rq;
    logic [7:0] pi;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: rq = REQ_GET_PAGE;
        3, 4, 5: rq = REQ_TRANSMIT;
        6: rq = REQ_FREE;
        default: rq = REQ_NIC_DONE;
      endcase
      pi = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, NPG - 1));
      send_request(rq, pi,
                   ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, rq_bias)),
                   ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                               : 16'($urandom_range(0, 2000)),
                   6'($urandom));
    end
  endtask

  task automatic test_random_settings();
    write_reg(CFG_MAX_LEN, 16'hFFFF);
    write_reg(CFG_MAX_DEST, 16'hFFFF);
    write_reg(CFG_TEST_DST, 16'd0);
    random_phase(400, 65535);
    write_reg(CFG_MAX_LEN, 16'd1);
    write_reg(CFG_MAX_DEST, 16'd0);
    write_reg(CFG_TEST_DST, 16'd77);
    random_phase(300, 100);
    write_reg(CFG_MAX_LEN, 16'd1500);
    write_reg(CFG_MAX_DEST, 16'd2000);
    write_reg(CFG_TEST_DST, 16'hAAAA);
    random_phase(500, 3000);
    write_reg(CFG_READY, 16'd0);
    random_phase(100, 3000);
    write_reg(CFG_READY, 16'd1);
    write_reg(CFG_MAX_LEN, 16'h5555);
    idle_on = 0;
    random_phase(450, 4000);
  endtask

  initial begin
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_closed_ring();
    test_directed_checks();
    test_random_settings();
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
